### src/tzpv_pkg.sv
// Shared constants for the three-zone proximity vote block.
package tzpv_pkg;

   localparam int unsigned COORD_W = 15;
   localparam int unsigned STEER_W = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned DIST_W  = 31;
   localparam int unsigned ZONE_W  = 2;
   localparam int unsigned INDEX_W = 3;

   localparam logic [DIST_W-1:0]  RADIUS_SQUARED = 31'd6400;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

   localparam logic [ZONE_W-1:0] ZONE_CENTRE = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_LEFT   = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_RIGHT  = 2'd2;

   localparam logic [INDEX_W-1:0] REG_AGENT_X  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_AGENT_Y  = 3'd1;
   localparam logic [INDEX_W-1:0] REG_CENTRE_X = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CENTRE_Y = 3'd3;
   localparam logic [INDEX_W-1:0] REG_LEFT_X   = 3'd4;
   localparam logic [INDEX_W-1:0] REG_LEFT_Y   = 3'd5;
   localparam logic [INDEX_W-1:0] REG_RIGHT_X  = 3'd6;
   localparam logic [INDEX_W-1:0] REG_RIGHT_Y  = 3'd7;

endpackage

### src/tzpv_zone_test.sv
// Squared-distance test of one marker against one circular sensing zone.
module tzpv_zone_test (
   input  logic [tzpv_pkg::COORD_W-1:0] zone_x,
   input  logic [tzpv_pkg::COORD_W-1:0] zone_y,
   input  logic [tzpv_pkg::COORD_W-1:0] marker_x,
   input  logic [tzpv_pkg::COORD_W-1:0] marker_y,
   output logic                         hit
);

   logic signed [15:0]                 dx;
   logic signed [15:0]                 dy;
   logic signed [31:0]                 sq_x;
   logic signed [31:0]                 sq_y;
   logic [tzpv_pkg::DIST_W-1:0]        dist_sq;

   assign dx = signed'({1'b0, zone_x}) - signed'({1'b0, marker_x});
   assign dy = signed'({1'b0, zone_y}) - signed'({1'b0, marker_y});
   assign sq_x = dx * dx;
   assign sq_y = dy * dy;

   // Each square is below 2**30, so the sum fits in 31 bits.
   assign dist_sq = {1'b0, sq_x[29:0]} + {1'b0, sq_y[29:0]};
   assign hit     = dist_sq < tzpv_pkg::RADIUS_SQUARED;

endmodule

### src/three_zone_proximity_vote_top.sv
// Result path: a last marker passes through stage one and stage two, and its result
// is then loaded into the output register; rsp_tvalid rises as it is loaded.
// Throughput: one marker per cycle; the distance squares run in the second stage and
// the hit counters update in the third, so nothing stalls unless the output is held.
// Reset: synchronous; clears the pipeline and output valid flags, the hit counters
// and all configuration registers to zero.
module three_zone_proximity_vote_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // marker_x, marker_y, pad
   input  logic                              req_tuser,  // marker_valid
   input  logic                              req_tlast,  // last_marker
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // winner_zone, steer_x, steer_y, centre_count, left_count, right_count, pad
   output logic [87:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tzpv_pkg::INDEX_W-1:0]      csr_index,
   input  logic [tzpv_pkg::COORD_W-1:0]      csr_data
);

   // Configuration registers.
   logic [tzpv_pkg::COORD_W-1:0] agent_x_ff, agent_y_ff;
   logic [tzpv_pkg::COORD_W-1:0] centre_x_ff, centre_y_ff;
   logic [tzpv_pkg::COORD_W-1:0] left_x_ff, left_y_ff;
   logic [tzpv_pkg::COORD_W-1:0] right_x_ff, right_y_ff;

   // Stage one: registered input.
   logic                         s1_valid_ff, s1_valid_in;
   logic [tzpv_pkg::COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic                         s1_mvalid_ff, s1_last_ff;

   // Stage two: registered zone hits.
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_mvalid_ff, s2_last_ff;
   logic                         s2_hit_c_ff, s2_hit_l_ff, s2_hit_r_ff;

   // Hit counters and output register.
   logic [tzpv_pkg::COUNT_W-1:0] centre_hits_ff, left_hits_ff, right_hits_ff;
   logic [tzpv_pkg::COUNT_W-1:0] centre_next, left_next, right_next;
   logic                         rsp_valid_ff;
   logic [tzpv_pkg::ZONE_W-1:0]  winner_ff, winner_in;
   logic [tzpv_pkg::STEER_W-1:0] steer_x_ff, steer_x_in;
   logic [tzpv_pkg::STEER_W-1:0] steer_y_ff, steer_y_in;
   logic [tzpv_pkg::COUNT_W-1:0] centre_cnt_ff, left_cnt_ff, right_cnt_ff;

   logic                         hit_c, hit_l, hit_r;
   logic                         req_fire, s1_move, s2_go, s2_ready, out_free;
   logic                         inc_c, inc_l, inc_r;
   logic [tzpv_pkg::COORD_W-1:0] win_x, win_y;

   // Handshake chain: a non-last item leaves stage two freely; a last one
   // needs the output register free.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s2_go       = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_ready    = !s2_valid_ff || s2_go;
   assign s1_move     = s1_valid_ff && s2_ready;
   assign req_tready  = !s1_valid_ff || s2_ready;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !s2_go);
   assign csr_ready   = 1'b1;

   tzpv_zone_test u_centre (
      .zone_x(centre_x_ff), .zone_y(centre_y_ff),
      .marker_x(s1_x_ff), .marker_y(s1_y_ff), .hit(hit_c)
   );
   tzpv_zone_test u_left (
      .zone_x(left_x_ff), .zone_y(left_y_ff),
      .marker_x(s1_x_ff), .marker_y(s1_y_ff), .hit(hit_l)
   );
   tzpv_zone_test u_right (
      .zone_x(right_x_ff), .zone_y(right_y_ff),
      .marker_x(s1_x_ff), .marker_y(s1_y_ff), .hit(hit_r)
   );

   // Only the first zone hit in priority order is counted.
   assign inc_c = s2_go && s2_mvalid_ff && s2_hit_c_ff;
   assign inc_l = s2_go && s2_mvalid_ff && !s2_hit_c_ff && s2_hit_l_ff;
   assign inc_r = s2_go && s2_mvalid_ff && !s2_hit_c_ff && !s2_hit_l_ff && s2_hit_r_ff;

   always_comb begin
      centre_next = centre_hits_ff;
      left_next   = left_hits_ff;
      right_next  = right_hits_ff;
      if (inc_c && centre_hits_ff != tzpv_pkg::COUNT_MAX) begin
         centre_next = centre_hits_ff + 16'd1;
      end
      if (inc_l && left_hits_ff != tzpv_pkg::COUNT_MAX) begin
         left_next = left_hits_ff + 16'd1;
      end
      if (inc_r && right_hits_ff != tzpv_pkg::COUNT_MAX) begin
         right_next = right_hits_ff + 16'd1;
      end
   end

   // Vote on the counts that include the last marker; ties go to the lower zone.
   always_comb begin
      if (centre_next >= left_next && centre_next >= right_next) begin
         winner_in = tzpv_pkg::ZONE_CENTRE;
         win_x     = centre_x_ff;
         win_y     = centre_y_ff;
      end else if (left_next >= centre_next && left_next >= right_next) begin
         winner_in = tzpv_pkg::ZONE_LEFT;
         win_x     = left_x_ff;
         win_y     = left_y_ff;
      end else begin
         winner_in = tzpv_pkg::ZONE_RIGHT;
         win_x     = right_x_ff;
         win_y     = right_y_ff;
      end
      steer_x_in = {1'b0, win_x} - {1'b0, agent_x_ff};
      steer_y_in = {1'b0, win_y} - {1'b0, agent_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agent_x_ff  <= '0;
         agent_y_ff  <= '0;
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         left_x_ff   <= '0;
         left_y_ff   <= '0;
         right_x_ff  <= '0;
         right_y_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tzpv_pkg::REG_AGENT_X:  agent_x_ff  <= csr_data;
            tzpv_pkg::REG_AGENT_Y:  agent_y_ff  <= csr_data;
            tzpv_pkg::REG_CENTRE_X: centre_x_ff <= csr_data;
            tzpv_pkg::REG_CENTRE_Y: centre_y_ff <= csr_data;
            tzpv_pkg::REG_LEFT_X:   left_x_ff   <= csr_data;
            tzpv_pkg::REG_LEFT_Y:   left_y_ff   <= csr_data;
            tzpv_pkg::REG_RIGHT_X:  right_x_ff  <= csr_data;
            tzpv_pkg::REG_RIGHT_Y:  right_y_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         centre_hits_ff <= '0;
         left_hits_ff   <= '0;
         right_hits_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s2_go) begin
            if (s2_last_ff) begin
               centre_hits_ff <= '0;
               left_hits_ff   <= '0;
               right_hits_ff  <= '0;
            end else begin
               centre_hits_ff <= centre_next;
               left_hits_ff   <= left_next;
               right_hits_ff  <= right_next;
            end
         end
         if (s2_go && s2_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_x_ff      <= req_tdata[14:0];
         s1_y_ff      <= req_tdata[29:15];
         s1_mvalid_ff <= req_tuser;
         s1_last_ff   <= req_tlast;
      end
      if (s1_move) begin
         s2_mvalid_ff <= s1_mvalid_ff;
         s2_last_ff   <= s1_last_ff;
         s2_hit_c_ff  <= hit_c;
         s2_hit_l_ff  <= hit_l;
         s2_hit_r_ff  <= hit_r;
      end
      if (s2_go && s2_last_ff) begin
         winner_ff     <= winner_in;
         steer_x_ff    <= steer_x_in;
         steer_y_ff    <= steer_y_in;
         centre_cnt_ff <= centre_next;
         left_cnt_ff   <= left_next;
         right_cnt_ff  <= right_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, right_cnt_ff, left_cnt_ff, centre_cnt_ff,
                        steer_y_ff, steer_x_ff, winner_ff};

`ifndef ASSERT_OFF
   a_one_counter_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({inc_c, inc_l, inc_r}))
      else $error("more than one zone counter stepped for one marker");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (s2_go && s2_last_ff) |=>
         (centre_hits_ff == '0 && left_hits_ff == '0 && right_hits_ff == '0))
      else $error("hit counters not cleared after a result");

   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s2_go && s2_last_ff))
      else $error("result appeared without a last marker");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s2_go && s2_last_ff))
      else $error("held result overwritten");
`endif

endmodule
